/* hw/rtl/ogg_pkg.sv */
// ============================================================================
// ogg_pkg: shared types and constants for the Ogg page stream validator
// Beat structures, failure codes and the CRC-32 byte step function.
// ============================================================================
package ogg_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam logic [31:0] CrcPoly = 32'h04c11db7;
   localparam logic [16:0] HdrBytes = 17'd27;

   typedef enum logic [3:0] {
      FAIL_NONE      = 4'd0,
      FAIL_CAPTURE   = 4'd1,
      FAIL_VERSION   = 4'd2,
      FAIL_FLAGS     = 4'd3,
      FAIL_TRUNCATED = 4'd4,
      FAIL_SERIAL    = 4'd5,
      FAIL_SEQUENCE  = 4'd6,
      FAIL_CRC       = 4'd7,
      FAIL_AFTER_END = 4'd8,
      FAIL_NO_END    = 4'd9
   } fail_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       stream_valid;
      logic [3:0] fail_reason;
   } rsp_type;

   // One byte through the non-reflected CRC-32 (eight dependent shift steps).
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int k = 0; k < 8; k++) begin
         c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

endpackage

/* hw/rtl/ogg_page_stream_validator_core.sv */
// ============================================================================
// ogg_page_stream_validator_core: Ogg page stream validator
// Checks capture, version, flags, serial, sequence and CRC of each page up to the first failure, and the stream end.
// ============================================================================
//   channel | direction | payload
//   req_    | in        | byte_value[7:0], last_byte
//   rsp_    | out       | stream_valid, fail_reason[3:0]
//
// One byte beat is taken per cycle unless a verdict held under rsp_stall backs up; the
// checker does the CRC byte step and all field checks combinationally for each beat.
// A verdict is registered and appears in the cycle after the checker takes the last byte.
// Reset is synchronous and active high and clears all control state.
// A stall on rsp_ backs up through the two-entry queue into req_stall.
module ogg_page_stream_validator_core #(
   parameter int unsigned QUEUE_DEPTH = ogg_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ogg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ogg_pkg::rsp_type rsp_data
);
   // Front: the queue accepts and buffers byte beats.
   logic             q_valid, q_stall;
   ogg_pkg::req_type q_data;

   ogg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .push_valid(req_valid), .push_stall(req_stall), .push_data(req_data),
      .pop_valid(q_valid), .pop_stall(q_stall), .pop_data(q_data)
   );

   // Back: page parser and checker with its own verdict register.
   ogg_check u_check (
      .clock, .reset,
      .in_valid(q_valid), .in_stall(q_stall), .in_data(q_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

`ifndef SYNTHESIS
   a_rsp_only_after_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_valid && !q_stall && q_data.last_byte))
      else $error("verdict without a last byte");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("verdict dropped");
   a_stall_path: assert property (@(posedge clock) disable iff (reset)
      (q_valid && !rsp_stall) |-> !q_stall) else $error("back stalled needlessly");
`endif
endmodule

/* hw/rtl/ogg_queue.sv */
// ============================================================================
// ogg_queue: short beat queue between the front and the back
// Registered FIFO with independent push and pop handshakes.
// ============================================================================
module ogg_queue #(
   parameter int unsigned DEPTH = ogg_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_stall,
   input  ogg_pkg::req_type push_data,
   output logic             pop_valid,
   input  logic             pop_stall,
   output ogg_pkg::req_type pop_data
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ogg_pkg::req_type mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign push_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      wr_in  = push ? ((wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
   a_pop_when_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count step");
`endif
endmodule

/* hw/rtl/ogg_check.sv */
// ============================================================================
// ogg_check: page parser and checker back end
// Follows page boundaries, updates the CRC and records the first failure.
// ============================================================================
module ogg_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  ogg_pkg::req_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ogg_pkg::rsp_type rsp_data
);
   logic [16:0] off_ff, off_in, len_ff, len_in;
   logic [7:0]  seg_ff, seg_in;
   logic [31:0] crc_ff, crc_in, chk_ff, chk_in, ser_ff, ser_in;
   logic [31:0] sh_ff, sh_in, seq_ff, seq_in;
   logic [2:0]  flg_ff, flg_in;
   logic        first_ff, first_in, end_ff, end_in;
   logic [3:0]  fail_ff, fail_in;
   logic        ov_ff, ov_in;
   ogg_pkg::rsp_type od_ff, od_in;
   logic        take;
   logic [7:0]  b;
   logic [3:0]  f;
   logic [31:0] crc_base;
   logic [17:0] pos_end;

   assign in_stall  = ov_ff && rsp_stall;
   assign take      = in_valid && !in_stall;
   assign rsp_valid = ov_ff;
   assign rsp_data  = od_ff;
   assign b         = in_data.byte_value;

   always_comb begin
      off_in = off_ff; len_in = len_ff; seg_in = seg_ff; crc_in = crc_ff;
      chk_in = chk_ff; ser_in = ser_ff; sh_in = sh_ff; seq_in = seq_ff;
      flg_in = flg_ff; first_in = first_ff; end_in = end_ff; fail_in = fail_ff;
      ov_in = ov_ff && rsp_stall; od_in = od_ff;
      f = ogg_pkg::FAIL_NONE;
      crc_base = (off_ff == '0) ? '0 : crc_ff;
      pos_end = '0;
      if (take && fail_ff == ogg_pkg::FAIL_NONE) begin
         if (off_ff == '0 && end_ff) begin
            f = ogg_pkg::FAIL_AFTER_END;
         end else begin
            if (off_ff == '0) begin
               len_in = '0;
               seg_in = '0;
            end
            crc_in = ogg_pkg::crc_byte(crc_base,
                     (off_ff >= 17'd22 && off_ff < 17'd26) ? 8'd0 : b);
            sh_in = {b, sh_ff[31:8]};
            priority if (off_ff < 17'd4) begin
               unique case (off_ff[1:0])
                  2'd0: if (b != 8'h4F) f = ogg_pkg::FAIL_CAPTURE;
                  2'd1: if (b != 8'h67) f = ogg_pkg::FAIL_CAPTURE;
                  2'd2: if (b != 8'h67) f = ogg_pkg::FAIL_CAPTURE;
                  default: if (b != 8'h53) f = ogg_pkg::FAIL_CAPTURE;
               endcase
            end else if (off_ff == 17'd4) begin
               if (b != 8'd0) f = ogg_pkg::FAIL_VERSION;
            end else if (off_ff == 17'd5) begin
               flg_in = b[2:0];
               if (b[7:3] != '0) f = ogg_pkg::FAIL_FLAGS;
               else if (first_ff && (!b[1] || b[0])) f = ogg_pkg::FAIL_FLAGS;
               else if (!first_ff && b[1]) f = ogg_pkg::FAIL_FLAGS;
            end else if (off_ff == 17'd17) begin
               if (first_ff) ser_in = sh_in;
               else if (sh_in != ser_ff) f = ogg_pkg::FAIL_SERIAL;
            end else if (off_ff == 17'd21) begin
               if (sh_in != seq_ff) f = ogg_pkg::FAIL_SEQUENCE;
               else seq_in = seq_ff + 32'd1;
            end else if (off_ff < 17'd26) begin
               chk_in = {b, chk_ff[31:8]};
            end else if (off_ff == 17'd26) begin
               seg_in = b;
               len_in = ogg_pkg::HdrBytes + 17'(b);
            end else if (off_ff <= 17'd26 + 17'(seg_ff)) begin
               len_in = len_ff + 17'(b);
            end
            pos_end = 18'(off_ff) + 18'd1;
            if (f == ogg_pkg::FAIL_NONE) begin
               if (off_ff >= 17'd26 && off_ff >= 17'd26 + 17'(seg_in)
                   && pos_end >= 18'(len_in)) begin
                  if (crc_in != chk_in) begin
                     f = ogg_pkg::FAIL_CRC;
                  end else begin
                     end_in = flg_in[2];
                     first_in = 1'b0;
                     off_in = '0;
                  end
               end else begin
                  off_in = off_ff + 17'd1;
               end
            end
         end
         fail_in = f;
      end
      if (take && in_data.last_byte) begin
         if (fail_in == ogg_pkg::FAIL_NONE) begin
            if (off_in != '0) fail_in = ogg_pkg::FAIL_TRUNCATED;
            else if (!end_in) fail_in = ogg_pkg::FAIL_NO_END;
         end
         od_in.stream_valid = (fail_in == ogg_pkg::FAIL_NONE);
         od_in.fail_reason  = fail_in;
         ov_in = 1'b1;
         off_in = '0; len_in = '0; seg_in = '0; crc_in = '0; chk_in = '0;
         ser_in = '0; sh_in = '0; seq_in = '0; flg_in = '0;
         first_in = 1'b1; end_in = 1'b0; fail_in = ogg_pkg::FAIL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0; len_ff <= '0; seg_ff <= '0; crc_ff <= '0; chk_ff <= '0;
         ser_ff <= '0; sh_ff <= '0; seq_ff <= '0; flg_ff <= '0;
         first_ff <= 1'b1; end_ff <= 1'b0; fail_ff <= ogg_pkg::FAIL_NONE;
         ov_ff <= 1'b0;
      end else begin
         off_ff <= off_in; len_ff <= len_in; seg_ff <= seg_in; crc_ff <= crc_in;
         chk_ff <= chk_in; ser_ff <= ser_in; sh_ff <= sh_in; seq_ff <= seq_in;
         flg_ff <= flg_in; first_ff <= first_in; end_ff <= end_in;
         fail_ff <= fail_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      od_ff <= od_in;
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_data)) else $error("rsp held");
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.stream_valid == (rsp_data.fail_reason == ogg_pkg::FAIL_NONE))
      else $error("verdict mismatch");
   a_reset_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && in_data.last_byte) |=> off_ff == '0 && first_ff && fail_ff == '0)
      else $error("state not cleared after last byte");
`endif
endmodule
